// ===== hw/rtl/bfha_pkg.sv =====
// -----------------------------------------------------------------------------
// bfha_pkg
// Types and constants shared by the best-fit heap allocator modules.
// -----------------------------------------------------------------------------
package bfha_pkg;

  localparam logic [31:0] SIZE_MASK  = 32'hFFFF_FFFC;
  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] NEG_HDR    = 32'hFFFF_FFFC;
  localparam logic [31:0] HDR_BYTES  = 32'd4;
  localparam logic [31:0] ROUND_ADD  = 32'd11;
  localparam logic [31:0] MIN_SPLIT  = 32'd8;
  localparam logic [31:0] HEAP_TAIL  = 32'd1;
  localparam logic [11:0] MAX_REQ_RST = 12'd4088;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_BAD_PTR  = 3'd3,
    ST_NOT_BUSY = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_A_RD,
    S_A_CHK,
    S_A_END,
    S_A_PB,
    S_A_RDN,
    S_A_SM,
    S_A_SM2,
    S_A_WB,
    S_A_WR2,
    S_F_RDH,
    S_F_HW,
    S_F_PS,
    S_F_NX,
    S_F_NW,
    S_F_PB1,
    S_F_PB2,
    S_F_PV,
    S_F_N1,
    S_F_N2,
    S_FT_RD,
    S_FT_ADD,
    S_FT_WR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic        we;
    logic [31:0] waddr;
    logic [31:0] wdata;
    logic [31:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] payload;
  } res_t;

endpackage

// ===== hw/rtl/best_fit_heap_allocator.sv =====
// -----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit heap allocator with boundary tags over an internal word memory.
// -----------------------------------------------------------------------------
// latency from accept to out_valid_o is shortest for a bad size or bad pointer,
//   answered from the check state; allocate reads one header per scan step
// throughput: one request at a time, the next accepted once the response is
//   registered; set by the single memory read port and shared adder
// reset: a clearing pass writes the initial heap word by word, with in_stall_o
//   high meanwhile
module best_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [11:0] request_bytes_i,
  input  logic [11:0] free_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [11:0] payload_offset_o
);

  logic               in_ready, res_valid, out_free, alu_sub;
  logic [11:0]        max_req_q;
  logic               out_valid_q;
  logic [2:0]         status_q;
  logic [11:0]        payload_q;
  logic [31:0]        rdata, alu_a, alu_b, alu_sum;
  bfha_pkg::res_t     res;
  bfha_pkg::mem_req_t mem_req;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q   <= bfha_pkg::MAX_REQ_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_req_q <= cfg_wdata_i;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      status_q  <= res.status;
      payload_q <= res.payload;
    end
  end

  bfha_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  bfha_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bfha_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .op_i            (op_i),
    .request_bytes_i (request_bytes_i),
    .free_offset_i   (free_offset_i),
    .max_request_i   (max_req_q),
    .in_ready_o      (in_ready),
    .out_free_i      (out_free),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (rdata),
    .alu_a_o         (alu_a),
    .alu_b_o         (alu_b),
    .alu_sub_o       (alu_sub),
    .alu_sum_i       (alu_sum)
  );

  assign in_stall_o       = !in_ready;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign payload_offset_o = payload_q;

endmodule

// ===== hw/rtl/bfha_alu.sv =====
// -----------------------------------------------------------------------------
// bfha_alu
// Shared 32-bit adder/subtractor used by the allocator sequencer.
// -----------------------------------------------------------------------------
module bfha_alu (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] sum_o
);

  logic [31:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_op + {31'b0, sub_i};

endmodule

// ===== hw/rtl/bfha_mem.sv =====
// -----------------------------------------------------------------------------
// bfha_mem
// Heap word memory, byte addressed, one write and one registered read a cycle.
// -----------------------------------------------------------------------------
module bfha_mem #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfha_pkg::mem_req_t req_i,
  output logic [31:0]        rdata_o
);

  localparam logic [31:0] HeapLen   = 32'(HEAP_BYTES) & 32'hFFFF_FFF8;
  localparam int unsigned HeapWords = HeapLen / 4;
  localparam int unsigned IW        = $clog2(HeapWords);

  logic [31:0] mem_q [HeapWords];
  logic [31:0] rdata_q;
  logic        oob_q;
  logic        w_in, r_in;
  logic [IW-1:0] widx, ridx;

  assign w_in = req_i.waddr < HeapLen;
  assign r_in = req_i.raddr < HeapLen;
  assign widx = req_i.waddr[IW+1:2];
  assign ridx = r_in ? req_i.raddr[IW+1:2] : '0;

  always_ff @(posedge clk_i) begin
    if (req_i.we && w_in) begin
      mem_q[widx] <= req_i.wdata;
    end
    rdata_q <= mem_q[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oob_q <= 1'b1;
    end else begin
      oob_q <= !r_in;
    end
  end

  assign rdata_o = oob_q ? 32'd0 : rdata_q;

endmodule

// ===== hw/rtl/bfha_seq.sv =====
// -----------------------------------------------------------------------------
// bfha_seq
// Request sequencer: clearing pass, best-fit scan, split, free and coalesce.
// -----------------------------------------------------------------------------
module bfha_seq #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               op_i,
  input  logic [11:0]        request_bytes_i,
  input  logic [11:0]        free_offset_i,
  input  logic [11:0]        max_request_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output bfha_pkg::res_t     res_o,
  output bfha_pkg::mem_req_t mem_req_o,
  input  logic [31:0]        mem_rdata_i,
  output logic [31:0]        alu_a_o,
  output logic [31:0]        alu_b_o,
  output logic               alu_sub_o,
  input  logic [31:0]        alu_sum_i
);

  localparam logic [31:0] HeapLen   = 32'(HEAP_BYTES) & 32'hFFFF_FFF8;
  localparam int unsigned HeapWords = HeapLen / 4;
  localparam int unsigned IW        = $clog2(HeapWords);
  localparam int unsigned SW        = $clog2(HeapWords + 1);

  bfha_pkg::state_e  state_q, state_d, ret_q, ret_d;
  bfha_pkg::op_e     op_q, op_d;
  bfha_pkg::status_e st_q, st_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [11:0]   req_q, req_d, off_q, off_d;
  logic [31:0]   need_q, need_d, pos_q, pos_d, best_q, best_d, bsize_q, bsize_d;
  logic [31:0]   hdr_q, hdr_d, fsize_q, fsize_d, nsize_q, nsize_d, prev_q, prev_d;
  logic [31:0]   t_q, t_d, a_q, a_d, fa_q, fa_d, sz_q, sz_d;
  logic          found_q, found_d, pb_q, pb_d, nb_q, nb_d;

  logic [31:0] rd_sz, clr_addr, clr_val;
  logic        accept, bad_size, bad_ptr, scan_go, stop_word, fit, exact;

  assign in_ready_o = state_q == bfha_pkg::S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_sz      = mem_rdata_i & bfha_pkg::SIZE_MASK;
  assign bad_size   = req_q == 12'd0 || req_q > max_request_i;
  assign bad_ptr    = off_q == 12'd0 || off_q[2:0] != 3'd0;
  assign scan_go    = pos_q < HeapLen && steps_q < SW'(HeapWords);
  assign stop_word  = mem_rdata_i == bfha_pkg::HEAP_TAIL || rd_sz == 32'd0;
  assign fit        = rd_sz >= need_q && (!found_q || rd_sz < bsize_q) && !mem_rdata_i[0];
  assign exact      = rd_sz == need_q;
  assign clr_addr   = {{(30-IW){1'b0}}, clr_q, 2'b00};

  always_comb begin
    clr_val = 32'd0;
    if (clr_q == IW'(1)) begin
      clr_val = (HeapLen - 32'd8) | 32'd2;
    end else if (clr_q == IW'(HeapWords - 2)) begin
      clr_val = HeapLen - 32'd8;
    end else if (clr_q == IW'(HeapWords - 1)) begin
      clr_val = bfha_pkg::HEAP_TAIL;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfha_pkg::S_CLR:    if (clr_q == IW'(HeapWords - 1)) state_d = bfha_pkg::S_IDLE;
      bfha_pkg::S_IDLE:   if (accept) state_d = bfha_pkg::S_CHECK;
      bfha_pkg::S_CHECK: begin
        if (op_q == bfha_pkg::OP_ALLOC) begin
          state_d = bad_size ? bfha_pkg::S_FIN : bfha_pkg::S_A_RD;
        end else begin
          state_d = bad_ptr ? bfha_pkg::S_FIN : bfha_pkg::S_F_RDH;
        end
      end
      bfha_pkg::S_A_RD:   state_d = scan_go ? bfha_pkg::S_A_CHK : bfha_pkg::S_A_END;
      bfha_pkg::S_A_CHK: begin
        state_d = (stop_word || (fit && exact)) ? bfha_pkg::S_A_END : bfha_pkg::S_A_RD;
      end
      bfha_pkg::S_A_END:  state_d = found_q ? bfha_pkg::S_A_PB : bfha_pkg::S_FIN;
      bfha_pkg::S_A_PB:   state_d = (t_q < bfha_pkg::MIN_SPLIT) ? bfha_pkg::S_A_RDN
                                                                : bfha_pkg::S_A_WB;
      bfha_pkg::S_A_RDN:  state_d = bfha_pkg::S_A_SM;
      bfha_pkg::S_A_SM:   state_d = bfha_pkg::S_A_SM2;
      bfha_pkg::S_A_SM2:  state_d = bfha_pkg::S_FIN;
      bfha_pkg::S_A_WB:   state_d = bfha_pkg::S_A_WR2;
      bfha_pkg::S_A_WR2:  state_d = bfha_pkg::S_FT_RD;
      bfha_pkg::S_F_RDH:  state_d = bfha_pkg::S_F_HW;
      bfha_pkg::S_F_HW: begin
        if (!mem_rdata_i[0]) begin
          state_d = bfha_pkg::S_FIN;
        end else begin
          state_d = mem_rdata_i[1] ? bfha_pkg::S_F_NX : bfha_pkg::S_F_PS;
        end
      end
      bfha_pkg::S_F_PS:   state_d = bfha_pkg::S_F_NX;
      bfha_pkg::S_F_NX:   state_d = bfha_pkg::S_F_NW;
      bfha_pkg::S_F_NW:   state_d = pb_q ? bfha_pkg::S_F_PB1 : bfha_pkg::S_F_PV;
      bfha_pkg::S_F_PB1:  state_d = nb_q ? bfha_pkg::S_F_PB2 : bfha_pkg::S_FT_RD;
      bfha_pkg::S_F_PB2:  state_d = bfha_pkg::S_FT_RD;
      bfha_pkg::S_F_PV:   state_d = bfha_pkg::S_FT_RD;
      bfha_pkg::S_F_N1:   state_d = bfha_pkg::S_F_N2;
      bfha_pkg::S_F_N2:   state_d = bfha_pkg::S_FIN;
      bfha_pkg::S_FT_RD:  state_d = bfha_pkg::S_FT_ADD;
      bfha_pkg::S_FT_ADD: state_d = bfha_pkg::S_FT_WR;
      bfha_pkg::S_FT_WR:  state_d = ret_q;
      bfha_pkg::S_FIN:    if (out_free_i) state_d = bfha_pkg::S_IDLE;
      default:            state_d = bfha_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    alu_a_o     = 32'd0;
    alu_b_o     = 32'd0;
    alu_sub_o   = 1'b0;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o.status  = st_q;
    res_o.payload = 12'd0;
    ret_d   = ret_q;   op_d    = op_q;    st_d    = st_q;    clr_d   = clr_q;
    steps_d = steps_q; req_d   = req_q;   off_d   = off_q;   need_d  = need_q;
    pos_d   = pos_q;   best_d  = best_q;  bsize_d = bsize_q; hdr_d   = hdr_q;
    fsize_d = fsize_q; nsize_d = nsize_q; prev_d  = prev_q;  t_d     = t_q;
    a_d     = a_q;     fa_d    = fa_q;    sz_d    = sz_q;    found_d = found_q;
    pb_d    = pb_q;    nb_d    = nb_q;
    unique case (state_q)
      bfha_pkg::S_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_addr;
        mem_req_o.wdata = clr_val;
        clr_d = clr_q + IW'(1);
      end
      bfha_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = bfha_pkg::op_e'(op_i);
          req_d = request_bytes_i;
          off_d = free_offset_i;
        end
      end
      bfha_pkg::S_CHECK: begin
        st_d = bfha_pkg::ST_OK;
        if (op_q == bfha_pkg::OP_ALLOC) begin
          alu_a_o = {20'd0, req_q};
          alu_b_o = bfha_pkg::ROUND_ADD;
          need_d  = alu_sum_i & bfha_pkg::ALIGN_MASK;
          pos_d   = bfha_pkg::HDR_BYTES;
          steps_d = '0;
          found_d = 1'b0;
          if (bad_size) st_d = bfha_pkg::ST_BAD_SIZE;
        end else begin
          alu_a_o = {20'd0, off_q};
          alu_b_o = bfha_pkg::NEG_HDR;
          hdr_d   = alu_sum_i;
          if (bad_ptr) st_d = bfha_pkg::ST_BAD_PTR;
        end
      end
      bfha_pkg::S_A_RD: mem_req_o.raddr = pos_q;
      bfha_pkg::S_A_CHK: begin
        if (!stop_word) begin
          if (fit) begin
            found_d = 1'b1;
            best_d  = pos_q;
            bsize_d = rd_sz;
          end
          alu_a_o = pos_q;
          alu_b_o = rd_sz;
          if (!(fit && exact)) begin
            pos_d   = alu_sum_i;
            steps_d = steps_q + SW'(1);
          end
        end
      end
      bfha_pkg::S_A_END: begin
        alu_a_o   = bsize_q;
        alu_b_o   = need_q;
        alu_sub_o = 1'b1;
        t_d       = alu_sum_i;
        mem_req_o.raddr = best_q;
        if (!found_q) st_d = bfha_pkg::ST_NO_FIT;
      end
      bfha_pkg::S_A_PB: begin
        pb_d    = mem_rdata_i[1];
        alu_a_o = best_q;
        alu_b_o = bsize_q;
        a_d     = alu_sum_i;
      end
      bfha_pkg::S_A_RDN: mem_req_o.raddr = a_q;
      bfha_pkg::S_A_SM: begin
        sz_d = mem_rdata_i;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = best_q;
        mem_req_o.wdata = bsize_q | {30'd0, pb_q, 1'b1};
      end
      bfha_pkg::S_A_SM2: begin
        mem_req_o.we    = sz_q != bfha_pkg::HEAP_TAIL;
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = sz_q | 32'd2;
      end
      bfha_pkg::S_A_WB: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = best_q;
        mem_req_o.wdata = need_q | {30'd0, pb_q, 1'b1};
        alu_a_o = best_q;
        alu_b_o = need_q;
        a_d     = alu_sum_i;
      end
      bfha_pkg::S_A_WR2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = t_q | 32'd2;
        fa_d  = a_q;
        ret_d = bfha_pkg::S_FIN;
      end
      bfha_pkg::S_F_RDH: mem_req_o.raddr = hdr_q;
      bfha_pkg::S_F_HW: begin
        if (!mem_rdata_i[0]) begin
          st_d = bfha_pkg::ST_NOT_BUSY;
        end else begin
          fsize_d = rd_sz;
          pb_d    = mem_rdata_i[1];
          alu_a_o = hdr_q;
          alu_b_o = bfha_pkg::NEG_HDR;
          mem_req_o.raddr = alu_sum_i;
        end
      end
      bfha_pkg::S_F_PS: begin
        alu_a_o   = hdr_q;
        alu_b_o   = mem_rdata_i;
        alu_sub_o = 1'b1;
        prev_d    = alu_sum_i;
      end
      bfha_pkg::S_F_NX: begin
        alu_a_o = hdr_q;
        alu_b_o = fsize_q;
        a_d     = alu_sum_i;
        mem_req_o.raddr = alu_sum_i;
      end
      bfha_pkg::S_F_NW: begin
        nb_d    = mem_rdata_i[0];
        nsize_d = rd_sz;
        alu_a_o = fsize_q;
        alu_b_o = rd_sz;
        t_d     = mem_rdata_i[0] ? fsize_q : alu_sum_i;
        mem_req_o.raddr = prev_q;
      end
      bfha_pkg::S_F_PB1: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hdr_q;
        mem_req_o.wdata = t_q | 32'd2;
        fa_d  = hdr_q;
        ret_d = bfha_pkg::S_FIN;
      end
      bfha_pkg::S_F_PB2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = nsize_q | 32'd1;
      end
      bfha_pkg::S_F_PV: begin
        alu_a_o = mem_rdata_i;
        alu_b_o = t_q;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = prev_q;
        mem_req_o.wdata = alu_sum_i;
        fa_d  = prev_q;
        ret_d = bfha_pkg::S_F_N1;
      end
      bfha_pkg::S_F_N1: begin
        mem_req_o.we    = nb_q;
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = nsize_q | 32'd1;
      end
      bfha_pkg::S_F_N2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hdr_q;
        mem_req_o.wdata = fsize_q | 32'd2;
      end
      bfha_pkg::S_FT_RD: mem_req_o.raddr = fa_q;
      bfha_pkg::S_FT_ADD: begin
        sz_d    = rd_sz;
        alu_a_o = fa_q;
        alu_b_o = rd_sz;
        fa_d    = alu_sum_i;
      end
      bfha_pkg::S_FT_WR: begin
        alu_a_o = fa_q;
        alu_b_o = bfha_pkg::NEG_HDR;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = alu_sum_i;
        mem_req_o.wdata = sz_q;
      end
      bfha_pkg::S_FIN: begin
        alu_a_o     = best_q;
        alu_b_o     = bfha_pkg::HDR_BYTES;
        res_valid_o = out_free_i;
        if (op_q == bfha_pkg::OP_ALLOC && st_q == bfha_pkg::ST_OK) begin
          res_o.payload = alu_sum_i[11:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfha_pkg::S_CLR;
      clr_q   <= '0;
      found_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      found_q <= found_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;   op_q    <= op_d;    st_q    <= st_d;    req_q   <= req_d;
    off_q   <= off_d;   need_q  <= need_d;  pos_q   <= pos_d;   best_q  <= best_d;
    bsize_q <= bsize_d; hdr_q   <= hdr_d;   fsize_q <= fsize_d; nsize_q <= nsize_d;
    prev_q  <= prev_d;  t_q     <= t_d;     a_q     <= a_d;     fa_q    <= fa_d;
    sz_q    <= sz_d;    pb_q    <= pb_d;    nb_q    <= nb_d;
  end

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == bfha_pkg::S_CHECK)
    else $error("accepted request did not start");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.payload != 12'd0 |-> res_o.status == bfha_pkg::ST_OK)
    else $error("payload on failed request");

  a_best_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfha_pkg::S_A_END && found_q |-> bsize_q >= need_q)
    else $error("chosen block too small");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= SW'(HeapWords))
    else $error("scan step count overrun");

endmodule
